// ===== src/vdu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vdu_pkg;

    localparam int ELEM_W  = 16;
    localparam int ACC_W   = 48;
    localparam int RAD_W   = 56;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int NROOT_W = ACC_W / 2;
    localparam int NUM_W   = 64;
    localparam int DIST_W  = 32;
    localparam int FRAC_SH = 16;
    localparam logic [DIST_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [DIST_W-1:0] DIST_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        SQ_L2,
        SQ_NORM_A,
        SQ_NORM_B
    } sq_sel_t;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_SQ_L2,
        ST_WAIT_L2,
        ST_SQ_A,
        ST_WAIT_A,
        ST_SQ_B,
        ST_WAIT_B,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_WAIT_DIV,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic    in_ready;
        logic    sq_start;
        sq_sel_t sq_sel;
        logic    ld_ra;
        logic    ld_den;
        logic    div_start;
        logic    res_ld;
    } vdu_cmd_t;

    typedef struct packed {
        logic last_xfer;
        logic sq_done;
        logic div_done;
        logic den_zero;
        logic metric;
        logic out_free;
    } vdu_status_t;

endpackage
`default_nettype wire

// ===== src/vdu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface vdu_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    modport source (output valid, output elem_a, output elem_b, input ready);
    modport sink (input valid, input elem_a, input elem_b, output ready);
endinterface

interface vdu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] distance;
    logic        saturated;
    modport source (output valid, output distance, output saturated, input ready);
    modport sink (input valid, input distance, input saturated, output ready);
endinterface
`default_nettype wire

// ===== src/vdu_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vdu_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [vdu_pkg::RAD_W-1:0]  radicand,
    output logic                            done,
    output logic [vdu_pkg::ROOT_W-1:0]      root
);
    import vdu_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W+3:0] rem_w;
    logic [ROOT_W+3:0] trial;

    always_comb
    begin
        rem_w     = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_w >= trial)
            begin
                rem_next  = (ROOT_W+2)'(rem_w - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_w[ROOT_W+1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== src/vdu_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vdu_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [vdu_pkg::NUM_W-1:0] num,
    input  wire logic [vdu_pkg::ACC_W-1:0] den,
    output logic                           done,
    output logic [vdu_pkg::NUM_W-1:0]      quo
);
    import vdu_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [ACC_W:0]   rem_w;

    always_comb
    begin
        rem_w     = {rem_reg, num_reg[NUM_W-1]};
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (rem_w >= {1'b0, den_reg})
            begin
                rem_next = ACC_W'(rem_w - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_w[ACC_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

// ===== src/vdu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vdu_datapath #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vdu_pkg::vdu_cmd_t    cmd,
    output vdu_pkg::vdu_status_t      status,
    input  wire logic                 metric,
    input  wire logic [10:0]          dimension,
    vdu_in_if.sink                    in_ch,
    vdu_out_if.source                 out_ch
);
    import vdu_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    p_valid_reg;
    logic signed [33:0]      p_sq_reg;
    logic signed [31:0]      p_ab_reg;
    logic signed [31:0]      p_aa_reg;
    logic signed [31:0]      p_bb_reg;
    logic [ACC_W-1:0]        ssd_reg, dot_reg, na_reg, nb_reg;
    logic [NROOT_W-1:0]      ra_reg;
    logic [ACC_W-1:0]        den_reg;
    logic                    out_valid_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    sat_reg;
    logic                    xfer;
    logic                    last;
    logic [31:0]             dim_eff;
    logic signed [16:0]      diff;
    logic [RAD_W-1:0]        radicand;
    logic                    sq_done;
    logic [ROOT_W-1:0]       root;
    logic                    div_done;
    logic [NUM_W-1:0]        quo;
    logic                    neg;
    logic [ACC_W-1:0]        mag;
    logic [NUM_W:0]          sum_neg;
    logic [DIST_W-1:0]       res_dist;
    logic                    res_sat;

    always_comb
    begin
        if (dimension == 11'd0)
            dim_eff = 32'd1;
        else if (32'(dimension) > 32'(MAX_DIM))
            dim_eff = 32'(MAX_DIM);
        else
            dim_eff = 32'(dimension);
    end

    assign in_ch.ready = cmd.in_ready;
    assign xfer        = in_ch.valid && cmd.in_ready;
    assign last        = (32'(count_reg) + 32'd1) >= dim_eff;
    assign count_next  = last ? '0 : count_reg + 1'b1;
    assign diff        = 17'(in_ch.elem_a) - 17'(in_ch.elem_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            p_valid_reg   <= 1'b0;
            ssd_reg       <= '0;
            dot_reg       <= '0;
            na_reg        <= '0;
            nb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= xfer;
            if (xfer)
                count_reg <= count_next;
            if (cmd.res_ld)
            begin
                ssd_reg <= '0;
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end
            else if (p_valid_reg)
            begin
                ssd_reg <= ssd_reg + ACC_W'(p_sq_reg);
                dot_reg <= dot_reg + ACC_W'(p_ab_reg);
                na_reg  <= na_reg + ACC_W'(p_aa_reg);
                nb_reg  <= nb_reg + ACC_W'(p_bb_reg);
            end
            if (cmd.res_ld)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            p_sq_reg <= diff * diff;
            p_ab_reg <= in_ch.elem_a * in_ch.elem_b;
            p_aa_reg <= in_ch.elem_a * in_ch.elem_a;
            p_bb_reg <= in_ch.elem_b * in_ch.elem_b;
        end
        if (cmd.ld_ra)
            ra_reg <= root[NROOT_W-1:0];
        if (cmd.ld_den)
            den_reg <= ra_reg * root[NROOT_W-1:0];
        if (cmd.res_ld)
        begin
            dist_reg <= res_dist;
            sat_reg  <= res_sat;
        end
    end

    always_comb
    begin
        case (cmd.sq_sel)
            SQ_L2:     radicand = {ssd_reg, 8'd0};
            SQ_NORM_A: radicand = RAD_W'(na_reg);
            SQ_NORM_B: radicand = RAD_W'(nb_reg);
            default:   radicand = '0;
        endcase
    end

    vdu_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (root)
    );

    assign neg = dot_reg[ACC_W-1];
    assign mag = neg ? ACC_W'(-dot_reg) : dot_reg;

    vdu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({mag, FRAC_SH'(0)}),
        .den   (den_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign sum_neg = (NUM_W+1)'(quo) + (NUM_W+1)'(ONE_Q16);

    always_comb
    begin
        res_sat  = 1'b0;
        res_dist = '0;
        if (!metric)
            res_dist = DIST_W'(root);
        else if (den_reg == '0)
            res_dist = ONE_Q16;
        else if (neg)
        begin
            if (sum_neg[NUM_W:DIST_W] != '0)
            begin
                res_dist = DIST_MAX;
                res_sat  = 1'b1;
            end
            else
                res_dist = sum_neg[DIST_W-1:0];
        end
        else if (quo > NUM_W'(ONE_Q16))
            res_dist = '0;
        else
            res_dist = ONE_Q16 - quo[DIST_W-1:0];
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.distance  = dist_reg;
    assign out_ch.saturated = sat_reg;

    assign status.last_xfer = xfer && last;
    assign status.sq_done   = sq_done;
    assign status.div_done  = div_done;
    assign status.den_zero  = (den_reg == '0);
    assign status.metric    = metric;
    assign status.out_free  = !out_valid_reg || out_ch.ready;
endmodule
`default_nettype wire

// ===== src/vdu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vdu_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vdu_pkg::vdu_status_t status,
    output vdu_pkg::vdu_cmd_t         cmd,
    output vdu_pkg::state_t           state
);
    import vdu_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM:    if (status.last_xfer) state_next = ST_DRAIN;
            ST_DRAIN:    state_next = status.metric ? ST_SQ_A : ST_SQ_L2;
            ST_SQ_L2:    state_next = ST_WAIT_L2;
            ST_WAIT_L2:  if (status.sq_done) state_next = ST_RESULT;
            ST_SQ_A:     state_next = ST_WAIT_A;
            ST_WAIT_A:   if (status.sq_done) state_next = ST_SQ_B;
            ST_SQ_B:     state_next = ST_WAIT_B;
            ST_WAIT_B:   if (status.sq_done) state_next = ST_MUL;
            ST_MUL:      state_next = ST_CHECK;
            ST_CHECK:    state_next = status.den_zero ? ST_RESULT : ST_DIV;
            ST_DIV:      state_next = ST_WAIT_DIV;
            ST_WAIT_DIV: if (status.div_done) state_next = ST_RESULT;
            ST_RESULT:   if (status.out_free) state_next = ST_ACCUM;
            default:     state_next = ST_ACCUM;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sq_sel = SQ_L2;
        case (state_reg)
            ST_ACCUM:
                cmd.in_ready = 1'b1;
            ST_SQ_L2:
                cmd.sq_start = 1'b1;
            ST_SQ_A:
            begin
                cmd.sq_start = 1'b1;
                cmd.sq_sel   = SQ_NORM_A;
            end
            ST_WAIT_A:
                cmd.ld_ra = status.sq_done;
            ST_SQ_B:
            begin
                cmd.sq_start = 1'b1;
                cmd.sq_sel   = SQ_NORM_B;
            end
            ST_MUL:
                cmd.ld_den = 1'b1;
            ST_DIV:
                cmd.div_start = 1'b1;
            ST_RESULT:
                cmd.res_ld = status.out_free;
            default:
                cmd.in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACCUM;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;
endmodule
`default_nettype wire

// ===== src/vector_distance_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming distance unit: each transfer carries one signed Q4.12 element pair, and after
// the configured dimension of pairs one unsigned Q16.16 distance leaves on the output
// channel, either the Euclidean distance or the cosine distance. Pairs other than the
// last of a vector are taken one per cycle. After the last pair the input stalls while
// the result is formed by a shared one-bit-per-cycle square root unit (28 steps) and a
// one-bit-per-cycle divider (64 steps): Euclidean mode takes one square root, cosine mode
// takes two square roots and a division, and the division is skipped when a norm is zero
// in cosine mode. Input resumes once the result is loaded into the output register.
module vector_distance_unit #(
    parameter int MAX_DIM = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    vdu_in_if.sink           in_ch,
    vdu_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import vdu_pkg::*;

    logic                 metric_reg;
    logic [10:0]          dim_reg;
    logic                 cfg_wr;
    vdu_cmd_t             cmd;
    vdu_status_t          status;
    state_t               state;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {21'd0, dim_reg} : {31'd0, metric_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= 1'b0;
            dim_reg    <= 11'd128;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                dim_reg <= pwdata[10:0];
            else
                metric_reg <= pwdata[0];
        end
    end

    vdu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .state  (state)
    );

    vdu_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .metric    (metric_reg),
        .dimension (dim_reg),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

`ifndef SYNTHESIS
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.saturated |-> out_ch.distance == 32'hFFFF_FFFF)
        else $error("saturated result without maximum distance");
    a_sat_cos: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.saturated |-> metric_reg)
        else $error("saturation in Euclidean mode");
    a_ready_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state == ST_ACCUM)
        else $error("input ready outside accumulation");
`endif
endmodule
`default_nettype wire
